[design/dtc_status_table_assert.svh]
// assertion macros for the dtc status table
`ifndef DTC_STATUS_TABLE_ASSERT_SVH
`define DTC_STATUS_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define DTC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dtc_status_table: assertion failed");
// next-cycle implication, checked out of reset
`define DTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dtc_status_table: assertion failed");
`else
`define DTC_ASSERT_IMPL(label, ante, cons)
`define DTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/dtc_st_pkg.sv]
package dtc_st_pkg;

   // table geometry
   localparam int NUM_ENTRIES = 15;
   localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS);

   // stream widths
   localparam int REQ_W = 56;
   localparam int RSP_W = 40;

   // fixed codes and status bits
   localparam logic [23:0] CODE_BASE         = 24'hC00001;
   localparam logic [23:0] GROUP_ALL         = 24'hFFFFFF;
   localparam logic [7:0]  ST_FAILED         = 8'h01;
   localparam logic [7:0]  ST_FAIL_CONFIRMED = 8'h09;
   localparam logic [7:0]  TYPE_BY_MASK      = 8'h02;

   typedef enum logic [1:0] {
      FUNC_REPORT      = 2'd0,
      FUNC_CLEAR_GROUP = 2'd1,
      FUNC_READ        = 2'd2,
      FUNC_CLEAR_ALL   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      RC_OK      = 3'd0,
      RC_SESSION = 3'd1,
      RC_DENIED  = 3'd2,
      RC_RANGE   = 3'd3,
      RC_SUBFUNC = 3'd4
   } rc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_SCAN_RD,
      ST_SCAN,
      ST_FINAL
   } state_type;

endpackage

[design/dtc_status_table.sv]
// DTC status table: one status byte per trouble code, code n being 0xC00001+n.
// Each request item yields zero or more record items and always one final
// item with tlast set and the response code. Requests are taken one at a time;
// the status bytes sit in a one-port-read, one-port-write synchronous memory
// with per-entry valid bits, so reset and the clear operations take effect at
// once with no clearing pass. A report goes through accept, read, write back
// and final item; the clear operations and any rejected request go from
// accept straight to the final item; read by status mask walks the table
// at one memory read per cycle while no record waits on a stalled result
// channel, then gives the final item. The next request is taken as soon as
// the final item is in the output register.
`include "dtc_status_table_assert.svh"

module dtc_status_table
   import dtc_st_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // dtc_index[3:0], fault_active[4], group_code[28:5], report_type[36:29],
   // status_mask[44:37], in_extended_session[45], security_level[53:46]
   input  logic [REQ_W-1:0] req_tdata,
   // func[1:0]
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // trouble_code[23:0], dtc_status[31:24], response_code[34:32]
   output logic [RSP_W-1:0] rsp_tdata,
   // is_record[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   // request fields
   logic [3:0]  req_dtc_index;
   logic        req_fault_active;
   logic [23:0] req_group_code;
   logic [7:0]  req_report_type;
   logic [7:0]  req_status_mask;
   logic        req_ext_session;
   logic [7:0]  req_security_level;
   func_type    req_func;

   assign req_dtc_index      = req_tdata[3:0];
   assign req_fault_active   = req_tdata[4];
   assign req_group_code     = req_tdata[28:5];
   assign req_report_type    = req_tdata[36:29];
   assign req_status_mask    = req_tdata[44:37];
   assign req_ext_session    = req_tdata[45];
   assign req_security_level = req_tdata[53:46];
   assign req_func           = func_type'(req_tuser);

   // control and request registers
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              active_ff;
   logic [7:0]        mask_ff;
   rc_type            rc_ff, rc_in;
   logic [ADDR_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]  rec_cnt_ff, rec_cnt_in;

   // status store with valid bits
   logic [7:0]             status_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [7:0]             mem_q_ff;
   logic                   valid_q_ff;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [7:0]             wr_data;
   logic                   clr_all;
   logic                   clr_one;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_rec_ff;
   logic [23:0] rsp_code_ff;
   logic [7:0]  rsp_status_ff;
   rc_type      rsp_rc_ff;
   logic        rsp_last_ff;
   logic        load_rec;
   logic        load_fin;
   logic        out_free;

   // decode helpers
   logic              accept;
   logic              idx_out_of_range;
   logic [23:0]       group_diff;
   logic              group_hit;
   logic [7:0]        cur_status;
   logic              cur_match;
   logic              cap_reached;
   logic              last_entry;

   assign accept           = req_tvalid && req_tready;
   assign out_free         = !rsp_valid_ff || rsp_tready;
   assign idx_out_of_range = {28'd0, req_dtc_index} >= 32'(NUM_ENTRIES);
   assign group_diff       = req_group_code - CODE_BASE;
   assign group_hit        = {8'd0, group_diff} < 32'(NUM_ENTRIES);
   assign cur_status       = valid_q_ff ? mem_q_ff : 8'd0;
   assign cur_match        = |(cur_status & mask_ff);
   assign cap_reached      = rec_cnt_ff == CNT_W'(MAX_RESULTS - 1);
   assign last_entry       = scan_cnt_ff == ADDR_W'(NUM_ENTRIES - 1);
   assign wr_data          = active_ff ? (cur_status | ST_FAIL_CONFIRMED)
                                       : (cur_status & ~ST_FAILED);

   // sequencer: next state, memory controls and output loads
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rc_in       = rc_ff;
      scan_cnt_in = scan_cnt_ff;
      rec_cnt_in  = rec_cnt_ff;
      req_tready  = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = scan_cnt_ff;
      wr_en       = 1'b0;
      clr_all     = 1'b0;
      clr_one     = 1'b0;
      load_rec    = 1'b0;
      load_fin    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rc_in       = RC_OK;
               state_in    = ST_FINAL;
               scan_cnt_in = '0;
               rec_cnt_in  = '0;
               unique case (req_func)
                  FUNC_REPORT: begin
                     idx_in = ADDR_W'(req_dtc_index);
                     if (idx_out_of_range) begin
                        rc_in = RC_RANGE;
                     end else begin
                        state_in = ST_RMW_RD;
                     end
                  end
                  FUNC_CLEAR_GROUP: begin
                     idx_in = ADDR_W'(group_diff);
                     priority if (!req_ext_session) begin
                        rc_in = RC_SESSION;
                     end else if (req_security_level == 8'd0) begin
                        rc_in = RC_DENIED;
                     end else if (req_group_code == GROUP_ALL) begin
                        clr_all = 1'b1;
                     end else if (group_hit) begin
                        clr_one = 1'b1;
                     end else begin
                        rc_in = RC_RANGE;
                     end
                  end
                  FUNC_READ: begin
                     if (req_report_type != TYPE_BY_MASK) begin
                        rc_in = RC_SUBFUNC;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  FUNC_CLEAR_ALL: begin
                     clr_all = 1'b1;
                  end
                  default: begin
                     state_in = ST_FINAL;
                  end
               endcase
            end
         end
         ST_RMW_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            // read and write fall in separate states, so no overlap on the entry
            wr_en    = 1'b1;
            state_in = ST_FINAL;
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = scan_cnt_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cur_match && cap_reached) begin
               // result list full: stop walking
               state_in = ST_FINAL;
            end else if (!cur_match || out_free) begin
               load_rec = cur_match;
               if (cur_match) begin
                  rec_cnt_in = rec_cnt_ff + CNT_W'(1);
               end
               if (last_entry) begin
                  state_in = ST_FINAL;
               end else begin
                  scan_cnt_in = scan_cnt_ff + ADDR_W'(1);
                  rd_en       = 1'b1;
                  rd_addr     = scan_cnt_ff + ADDR_W'(1);
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               load_fin = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_cnt_ff <= '0;
         rec_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         rec_cnt_ff  <= rec_cnt_in;
      end
   end

   // request payload held for the whole operation
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rc_ff  <= rc_in;
      if (accept) begin
         active_ff <= req_fault_active;
         mask_ff   <= req_status_mask;
      end
   end

   // valid bits: an invalid entry reads as zero
   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         valid_ff <= '0;
      end else begin
         if (clr_one) begin
            valid_ff[idx_in] <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // status memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         status_mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff   <= status_mem[rd_addr];
         valid_q_ff <= valid_ff[rd_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rec || load_fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rec) begin
         rsp_rec_ff    <= 1'b1;
         rsp_code_ff   <= CODE_BASE + 24'(scan_cnt_ff);
         rsp_status_ff <= cur_status;
         rsp_rc_ff     <= RC_OK;
         rsp_last_ff   <= 1'b0;
      end else if (load_fin) begin
         rsp_rec_ff    <= 1'b0;
         rsp_code_ff   <= 24'd0;
         rsp_status_ff <= 8'd0;
         rsp_rc_ff     <= rc_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_rec_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_rc_ff, rsp_status_ff, rsp_code_ff};

   // checks
   `DTC_ASSERT_IMPL(a_record_not_last, rsp_valid_ff && rsp_rec_ff, !rsp_last_ff)
   `DTC_ASSERT_IMPL(a_status_is_last, rsp_valid_ff && !rsp_rec_ff, rsp_last_ff)
   `DTC_ASSERT_NEXT(a_one_at_a_time, accept, !req_tready)
   `DTC_ASSERT_IMPL(a_scan_in_table, state_ff == ST_SCAN, scan_cnt_ff <= ADDR_W'(NUM_ENTRIES - 1))
   `DTC_ASSERT_IMPL(a_no_load_clash, load_rec, !load_fin && out_free)

endmodule

[sim/dtc_status_checker.sv]
// watches both channels of the dtc status table, predicts every result item
// from its own copy of the status bytes and compares in arrival order
module dtc_status_checker
   import dtc_st_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // dtc_index[3:0], fault_active[4], group_code[28:5], report_type[36:29],
   // status_mask[44:37], in_extended_session[45], security_level[53:46]
   input  logic [REQ_W-1:0] req_tdata,
   // func[1:0]
   input  logic [1:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // trouble_code[23:0], dtc_status[31:24], response_code[34:32]
   input  logic [RSP_W-1:0] rsp_tdata,
   // is_record[0]
   input  logic             rsp_tuser,
   input  logic             rsp_tlast,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        is_record;
      logic [23:0] code;
      logic [7:0]  status;
      logic [2:0]  rc;
      logic        last;
   } dtc_item_type;

   logic [7:0]   status_copy [NUM_ENTRIES];
   dtc_item_type expected_items [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic wipe_copy();
      int i;
      for (i = 0; i < NUM_ENTRIES; i++) begin
         status_copy[i] = 8'h00;
      end
   endtask

   task automatic queue_item(input logic rec, input logic [23:0] code,
                             input logic [7:0] status, input rc_type rc);
      dtc_item_type it;
      it.is_record = rec;
      it.code      = code;
      it.status    = status;
      it.rc        = rc;
      it.last      = !rec;
      expected_items.push_back(it);
   endtask

   // apply one request to the status copy and queue what it answers
   task automatic predict_request(input func_type fn, input logic [REQ_W-1:0] d);
      logic [3:0]  idx;
      logic        active;
      logic [23:0] group;
      logic [7:0]  rtype;
      logic [7:0]  mask;
      logic        ext;
      logic [7:0]  sec;
      rc_type      rc;
      int          n;
      int          i;
      bit          hit;
      idx    = d[3:0];
      active = d[4];
      group  = d[28:5];
      rtype  = d[36:29];
      mask   = d[44:37];
      ext    = d[45];
      sec    = d[53:46];
      rc     = RC_OK;
      n      = 0;
      hit    = 1'b0;
      case (fn)
         FUNC_REPORT: begin
            if (idx >= NUM_ENTRIES) begin
               rc = RC_RANGE;
            end else if (active) begin
               status_copy[idx] = status_copy[idx] | ST_FAIL_CONFIRMED;
            end else begin
               status_copy[idx] = status_copy[idx] & ~ST_FAILED;
            end
         end
         FUNC_CLEAR_GROUP: begin
            // session is tested before security
            if (!ext) begin
               rc = RC_SESSION;
            end else if (sec == 8'h00) begin
               rc = RC_DENIED;
            end else if (group == GROUP_ALL) begin
               wipe_copy();
            end else begin
               rc = RC_RANGE;
               for (i = 0; i < NUM_ENTRIES; i++) begin
                  if (!hit && (CODE_BASE + 24'(i)) == group) begin
                     status_copy[i] = 8'h00;
                     rc  = RC_OK;
                     hit = 1'b1;
                  end
               end
            end
         end
         FUNC_READ: begin
            if (rtype != TYPE_BY_MASK) begin
               rc = RC_SUBFUNC;
            end else begin
               // records in index order, at most one short of a full list
               for (i = 0; i < NUM_ENTRIES; i++) begin
                  if ((status_copy[i] & mask) != 8'h00 && n < MAX_RESULTS - 1) begin
                     queue_item(1'b1, CODE_BASE + 24'(i), status_copy[i], RC_OK);
                     n++;
                  end
               end
            end
         end
         default: begin
            wipe_copy();
         end
      endcase
      queue_item(1'b0, 24'h000000, 8'h00, rc);
   endtask

   // compare one accepted result item with the oldest expectation
   task automatic check_item();
      dtc_item_type got;
      dtc_item_type want;
      got.is_record = rsp_tuser;
      got.code      = rsp_tdata[23:0];
      got.status    = rsp_tdata[31:24];
      got.rc        = rsp_tdata[34:32];
      got.last      = rsp_tlast;
      if (expected_items.size() == 0) begin
         report_mismatch($sformatf(
            "unexpected item rec=%0d code=%h status=%h rc=%0d last=%0d",
            got.is_record, got.code, got.status, got.rc, got.last));
      end else begin
         want = expected_items.pop_front();
         if (got.is_record !== want.is_record || got.code !== want.code ||
             got.status !== want.status || got.rc !== want.rc ||
             got.last !== want.last || rsp_tdata[RSP_W-1:35] !== '0) begin
            report_mismatch($sformatf(
               {"got rec=%0d code=%h status=%h rc=%0d last=%0d pad=%h, ",
                "want rec=%0d code=%h status=%h rc=%0d last=%0d"},
               got.is_record, got.code, got.status, got.rc, got.last,
               rsp_tdata[RSP_W-1:35],
               want.is_record, want.code, want.status, want.rc, want.last));
         end
      end
   endtask

   // results first, then the request taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         wipe_copy();
         expected_items.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_item();
         end
         if (req_tvalid && req_tready) begin
            predict_request(func_type'(req_tuser), req_tdata);
         end
      end
      pending <= expected_items.size();
   end

endmodule

[sim/tb_dtc_status_table.sv]
module tb_dtc_status_table;
   import dtc_st_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // dtc_index[3:0], fault_active[4], group_code[28:5], report_type[36:29],
   // status_mask[44:37], in_extended_session[45], security_level[53:46]
   logic [REQ_W-1:0] req_tdata  = '0;
   // func[1:0]
   logic [1:0]       req_tuser  = 2'b00;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // trouble_code[23:0], dtc_status[31:24], response_code[34:32]
   logic [RSP_W-1:0] rsp_tdata;
   // is_record[0]
   logic             rsp_tuser;
   logic             rsp_tlast;

   int fail_count;
   int pending;
   bit tx_burst    = 1'b0;
   bit rx_burst    = 1'b0;
   bit rx_hold_req = 1'b0;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   dtc_status_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dtc_status_checker u_status_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // offer one request item after a random gap and wait for it to be taken
   task automatic send_request(input func_type fn, input logic [3:0] idx,
                               input logic active, input logic [23:0] group,
                               input logic [7:0] rtype, input logic [7:0] mask,
                               input logic ext, input logic [7:0] sec);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {2'b00, sec, ext, mask, rtype, group, active, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly well-formed requests with random content in every field
   task automatic send_random();
      int          pick;
      int          sel;
      func_type    fn;
      logic [3:0]  idx;
      logic        active;
      logic [23:0] group;
      logic [7:0]  rtype;
      logic [7:0]  mask;
      logic        ext;
      logic [7:0]  sec;
      pick   = $urandom_range(0, 99);
      sel    = $urandom_range(0, 99);
      idx    = (sel < 90) ? 4'($urandom_range(0, NUM_ENTRIES - 1)) : 4'd15;
      active = ($urandom_range(0, 9) < 7);
      group  = 24'($urandom);
      rtype  = 8'($urandom);
      mask   = 8'($urandom);
      ext    = 1'($urandom);
      sec    = 8'($urandom);
      if (pick < 45) begin
         fn = FUNC_REPORT;
      end else if (pick < 58) begin
         fn = FUNC_CLEAR_GROUP;
         if (sel < 85) begin
            ext = 1'b1;
            sec = 8'($urandom_range(1, 255));
         end
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            group = CODE_BASE + 24'($urandom_range(0, NUM_ENTRIES - 1));
         end else if (sel < 70) begin
            group = GROUP_ALL;
         end else if (sel < 80) begin
            group = CODE_BASE + 24'($urandom_range(NUM_ENTRIES, 40));
         end
      end else if (pick < 96) begin
         fn = FUNC_READ;
         if (sel < 85) begin
            rtype = TYPE_BY_MASK;
         end
         if ($urandom_range(0, 4) == 0) begin
            mask = 8'hFF;
         end
      end else begin
         fn = FUNC_CLEAR_ALL;
      end
      send_request(fn, idx, active, group, rtype, mask, ext, sec);
   endtask

   // hold the sender idle until the table has answered everything
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // result side: random stalls, bursts without stalls, one long hold
   initial begin
      int stall;
      int taken;
      taken = 0;
      forever begin
         stall = rx_burst ? 0 : $urandom_range(0, 14);
         if (rx_hold_req) begin
            stall       = 300;
            rx_hold_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (taken % 40 == 0) begin
            rx_burst = ($urandom_range(0, 2) == 0);
         end
      end
   end

   // request side
   initial begin
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table answers with the final item only
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, TYPE_BY_MASK, 8'hFF, 1'b0, 8'h00);
      // reports at both ends of the table, in the middle and past the end
      send_request(FUNC_REPORT, 4'd0, 1'b1, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      send_request(FUNC_REPORT, 4'd14, 1'b1, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00);
      send_request(FUNC_REPORT, 4'd7, 1'b1, 24'h5A5A5A, 8'h33, 8'hCC, 1'b0, 8'h01);
      send_request(FUNC_REPORT, 4'd15, 1'b1, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00);
      // fault gone keeps the confirmed bit
      send_request(FUNC_REPORT, 4'd14, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00);
      send_request(FUNC_REPORT, 4'd3, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00);
      // masks selecting all, failed only, confirmed only, nothing
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, TYPE_BY_MASK, 8'hFF, 1'b0, 8'h00);
      send_request(FUNC_READ, 4'd15, 1'b1, 24'hFFFFFF, TYPE_BY_MASK, 8'h01, 1'b1, 8'hFF);
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, TYPE_BY_MASK, 8'h08, 1'b0, 8'h00);
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, TYPE_BY_MASK, 8'h00, 1'b0, 8'h00);
      // unsupported report types
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, 8'h00, 8'hFF, 1'b0, 8'h00);
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, 8'hFF, 8'hFF, 1'b0, 8'h00);
      // clear by group: session before security, then lock, then no match
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, CODE_BASE, 8'h00, 8'h00, 1'b0, 8'h00);
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, CODE_BASE, 8'h00, 8'h00, 1'b0, 8'hFF);
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, CODE_BASE, 8'h00, 8'h00, 1'b1, 8'h00);
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b1, 8'h01);
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, CODE_BASE + 24'd15, 8'h00, 8'h00, 1'b1, 8'h01);
      // clear by group hitting the last and the first code
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, CODE_BASE + 24'd14, 8'h00, 8'h00, 1'b1, 8'h01);
      send_request(FUNC_CLEAR_GROUP, 4'd15, 1'b1, CODE_BASE, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, TYPE_BY_MASK, 8'hFF, 1'b0, 8'h00);
      // group of all codes, then clear all with every unused field set
      send_request(FUNC_CLEAR_GROUP, 4'd0, 1'b0, GROUP_ALL, 8'h00, 8'h00, 1'b1, 8'h80);
      send_request(FUNC_REPORT, 4'd5, 1'b1, 24'h000000, 8'h00, 8'h00, 1'b0, 8'h00);
      send_request(FUNC_CLEAR_ALL, 4'd15, 1'b1, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      send_request(FUNC_READ, 4'd0, 1'b0, 24'h000000, TYPE_BY_MASK, 8'hFF, 1'b0, 8'h00);

      // random part with burst phases, a long result hold and one drain
      for (k = 0; k < 480; k++) begin
         if (k % 40 == 0) begin
            tx_burst = ($urandom_range(0, 2) == 0);
         end
         if (k == 150) begin
            rx_hold_req = 1'b1;
         end
         if (k == 300) begin
            wait_drained();
         end
         send_random();
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
